@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL. In synthesis builds they expand to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// The condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Whenever the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst, cond, msg)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg)

`endif

`endif

@@ rtl/idll_pkg.sv @@
`timescale 1ns / 1ps

package idll_pkg;

  // Default sizing of the slot table.
  localparam int SLOTS_DEF     = 64;
  localparam int DATA_BITS_DEF = 32;

  // Fixed widths of the command and result fields.
  localparam int MODE_BITS   = 3;
  localparam int POS_BITS    = 6;
  localparam int VAL_BITS    = 32;
  localparam int STATUS_BITS = 3;

  // Command modes.
  localparam logic [MODE_BITS-1:0] MODE_INS_AFTER  = 3'd0;
  localparam logic [MODE_BITS-1:0] MODE_ERASE      = 3'd1;
  localparam logic [MODE_BITS-1:0] MODE_INS_HEAD   = 3'd2;
  localparam logic [MODE_BITS-1:0] MODE_INS_TAIL   = 3'd3;
  localparam logic [MODE_BITS-1:0] MODE_ERASE_HEAD = 3'd4;
  localparam logic [MODE_BITS-1:0] MODE_ERASE_TAIL = 3'd5;
  localparam logic [MODE_BITS-1:0] MODE_READ       = 3'd6;

  // Result status codes.
  localparam logic [STATUS_BITS-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_BITS-1:0] ST_RANGE   = 3'd1;
  localparam logic [STATUS_BITS-1:0] ST_FULL    = 3'd2;
  localparam logic [STATUS_BITS-1:0] ST_EMPTY   = 3'd3;
  localparam logic [STATUS_BITS-1:0] ST_BADSLOT = 3'd4;

endpackage

@@ rtl/idll_cmd_if.sv @@
`timescale 1ns / 1ps

// Command channel: one word per list operation.
interface idll_cmd_if import idll_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [MODE_BITS-1:0]       mode;
  logic [POS_BITS-1:0]        position;
  logic signed [VAL_BITS-1:0] value;

  modport source (output valid, output mode, output position, output value, input ready);
  modport sink   (input valid, input mode, input position, input value, output ready);
endinterface

@@ rtl/idll_res_if.sv @@
`timescale 1ns / 1ps

// Result channel: one word per completed operation.
interface idll_res_if import idll_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [STATUS_BITS-1:0]     status;
  logic [POS_BITS-1:0]        slot;
  logic [POS_BITS-1:0]        head_index;
  logic [POS_BITS-1:0]        tail_index;
  logic signed [VAL_BITS-1:0] read_value;
  logic [POS_BITS-1:0]        read_next;
  logic [POS_BITS-1:0]        read_prev;
  logic                       read_free;

  modport source (output valid, output status, output slot, output head_index,
                  output tail_index, output read_value, output read_next,
                  output read_prev, output read_free, input ready);
  modport sink   (input valid, input status, input slot, input head_index,
                  input tail_index, input read_value, input read_next,
                  input read_prev, input read_free, output ready);
endinterface

@@ rtl/indexed_doubly_linked_list.sv @@
// Doubly linked list kept in a table of SLOTS slots, with slot 0 as sentinel (its next link
// is the head, its prev link the tail) and the unused slots on a FIFO free list. Each
// accepted command word inserts, erases or reads one slot and returns exactly one result
// word with a status, the slot filled or freed, and the head and tail after the command.
// Slot data, links and free bits live in one slot memory with a single read port, and every
// linked entry is fetched and rewritten in turn: a read or a rejected command answers from the
// fetch state, an insert goes on through steps 2 and 3, and an erase through steps 2 to 4.
// Commands are taken one at a time; the result sits in an output register, so the next
// command is accepted while an earlier result still waits. After reset the slot memory is
// initialized by a pass over all SLOTS slots during which no command is accepted; writes of the
// poison value are taken at any time and apply to slots freed afterwards.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module indexed_doubly_linked_list import idll_pkg::*; #(
  parameter int SLOTS     = SLOTS_DEF,
  parameter int DATA_BITS = DATA_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  idll_cmd_if.sink                   cmd,
  idll_res_if.source                 res,
  input  logic                       cfg_we,
  input  logic signed [VAL_BITS-1:0] cfg_data
);

  localparam int            IW        = $clog2(SLOTS);
  localparam int            WW        = DATA_BITS + 2 * IW + 1;
  localparam logic [IW-1:0] LAST_SLOT = IW'(SLOTS - 1);

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_FETCH = 6'b000100,
    ST_STEP2 = 6'b001000,
    ST_STEP3 = 6'b010000,
    ST_STEP4 = 6'b100000
  } state_t;

  // Memory word layout: {data, next, prev, free}.
  function automatic logic [WW-1:0] pack_word(logic [DATA_BITS-1:0] d, logic [IW-1:0] nx,
                                              logic [IW-1:0] pv, logic fr);
    return {d, nx, pv, fr};
  endfunction

  state_t               state, state_next;
  logic [IW-1:0]        clr_idx, clr_idx_next;
  logic [IW-1:0]        head, head_next;
  logic [IW-1:0]        tail, tail_next;
  logic [IW-1:0]        free_head, free_head_next;
  logic [IW-1:0]        free_tail, free_tail_next;
  logic [IW-1:0]        slot_n, slot_n_next;
  logic [IW-1:0]        link_a, link_a_next;
  logic [IW-1:0]        link_b, link_b_next;
  logic                 res_valid;
  logic [DATA_BITS-1:0] poison;

  // Latched command.
  logic [MODE_BITS-1:0] op_mode;
  logic [IW-1:0]        op_p;
  logic [DATA_BITS-1:0] op_val;
  logic                 op_range;

  logic          accept;
  logic [IW-1:0] p_sel;
  logic          range_sel;

  // Slot memory port.
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [WW-1:0] ram_wdata;
  logic          ram_re;
  logic [IW-1:0] ram_raddr;
  logic [WW-1:0] ram_rdata;

  logic [DATA_BITS-1:0] q_data;
  logic [IW-1:0]        q_next;
  logic [IW-1:0]        q_prev;
  logic                 q_free;

  // Fields of the addressed slot, with the sentinel taken from the head and tail registers.
  logic                 p_zero;
  logic                 p_free;
  logic [IW-1:0]        p_next;
  logic [IW-1:0]        p_prev;
  logic [DATA_BITS-1:0] p_data;

  logic                   is_ins;
  logic                   is_era;
  logic                   is_rd;
  logic                   mode_ok;
  logic [STATUS_BITS-1:0] fetch_status;
  logic                   out_free;

  // Result word staging.
  logic                   res_load;
  logic [STATUS_BITS-1:0] res_status_d;
  logic [POS_BITS-1:0]    res_slot_d;
  logic [POS_BITS-1:0]    res_head_d;
  logic [POS_BITS-1:0]    res_tail_d;
  logic [VAL_BITS-1:0]    res_rvalue_d;
  logic [POS_BITS-1:0]    res_rnext_d;
  logic [POS_BITS-1:0]    res_rprev_d;
  logic                   res_rfree_d;

  logic [STATUS_BITS-1:0] res_status;
  logic [POS_BITS-1:0]    res_slot;
  logic [POS_BITS-1:0]    res_head;
  logic [POS_BITS-1:0]    res_tail;
  logic [VAL_BITS-1:0]    res_rvalue;
  logic [POS_BITS-1:0]    res_rnext;
  logic [POS_BITS-1:0]    res_rprev;
  logic                   res_rfree;

  idll_ram #(
    .WIDTH (WW),
    .DEPTH (SLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign q_free = ram_rdata[0];
  assign q_prev = ram_rdata[IW:1];
  assign q_next = ram_rdata[2*IW:IW+1];
  assign q_data = ram_rdata[WW-1:2*IW+1];

  assign p_zero = (op_p == '0);
  assign p_free = !p_zero && q_free;
  assign p_next = p_zero ? head : q_next;
  assign p_prev = p_zero ? tail : q_prev;
  assign p_data = p_zero ? '0 : q_data;

  assign is_ins  = op_mode inside {MODE_INS_AFTER, MODE_INS_HEAD, MODE_INS_TAIL};
  assign is_era  = op_mode inside {MODE_ERASE, MODE_ERASE_HEAD, MODE_ERASE_TAIL};
  assign is_rd   = (op_mode == MODE_READ);
  assign mode_ok = is_ins || is_era || is_rd;

  assign accept   = cmd.valid && cmd.ready;
  assign out_free = !res_valid || res.ready;

  assign cmd.ready = (state == ST_IDLE);

  // Slot that the incoming command works on.
  always_comb begin
    case (cmd.mode)
      MODE_INS_HEAD:                  p_sel = '0;
      MODE_INS_TAIL, MODE_ERASE_TAIL: p_sel = tail;
      MODE_ERASE_HEAD:                p_sel = head;
      default:                        p_sel = IW'(cmd.position);
    endcase
  end

  assign range_sel = (cmd.mode inside {MODE_INS_AFTER, MODE_ERASE, MODE_READ}) &&
                     (int'(cmd.position) >= SLOTS);

  // Status once the addressed slot has been fetched; checks follow the priority of the spec.
  always_comb begin
    if (op_range || !mode_ok) begin
      fetch_status = ST_RANGE;
    end else if (is_ins) begin
      if (free_head == '0) begin
        fetch_status = ST_FULL;
      end else if (p_free) begin
        fetch_status = ST_BADSLOT;
      end else begin
        fetch_status = ST_OK;
      end
    end else if (is_era) begin
      if (head == '0) begin
        fetch_status = ST_EMPTY;
      end else if (p_zero || p_free) begin
        fetch_status = ST_BADSLOT;
      end else begin
        fetch_status = ST_OK;
      end
    end else begin
      fetch_status = ST_OK;
    end
  end

  // Sequencer. Each step reads at most one entry and writes at most one other entry; the
  // entries touched by one command are always distinct, so no read ever needs forwarding.
  always_comb begin
    state_next     = state;
    clr_idx_next   = clr_idx;
    head_next      = head;
    tail_next      = tail;
    free_head_next = free_head;
    free_tail_next = free_tail;
    slot_n_next    = slot_n;
    link_a_next    = link_a;
    link_b_next    = link_b;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = '0;
    ram_re         = 1'b0;
    ram_raddr      = '0;
    res_load       = 1'b0;
    res_status_d   = ST_OK;
    res_slot_d     = '0;
    res_rvalue_d   = '0;
    res_rnext_d    = '0;
    res_rprev_d    = '0;
    res_rfree_d    = 1'b0;

    case (state)
      // Initialize every slot as free, chained in index order.
      ST_CLEAR: begin
        ram_we       = 1'b1;
        ram_waddr    = clr_idx;
        ram_wdata    = pack_word('0, (clr_idx == LAST_SLOT) ? '0 : clr_idx + 1'b1, '0, 1'b1);
        clr_idx_next = clr_idx + 1'b1;
        if (clr_idx == LAST_SLOT) begin
          state_next = ST_IDLE;
        end
      end

      // Take a command and fetch its slot.
      ST_IDLE: begin
        if (cmd.valid) begin
          ram_re     = 1'b1;
          ram_raddr  = p_sel;
          state_next = ST_FETCH;
        end
      end

      ST_FETCH: begin
        if (fetch_status != ST_OK || is_rd) begin
          // Rejected command or read: answer as soon as the output register is free.
          if (out_free) begin
            res_load     = 1'b1;
            res_status_d = fetch_status;
            if (is_rd && fetch_status == ST_OK) begin
              res_rvalue_d = VAL_BITS'(p_data);
              res_rnext_d  = POS_BITS'(p_next);
              res_rprev_d  = POS_BITS'(p_prev);
              res_rfree_d  = p_free;
            end
            state_next = ST_IDLE;
          end
        end else if (is_ins) begin
          // Point the predecessor at the new slot and fetch the new slot.
          slot_n_next = free_head;
          link_a_next = p_next;
          if (p_zero) begin
            head_next = free_head;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = op_p;
            ram_wdata = pack_word(q_data, free_head, q_prev, q_free);
          end
          ram_re     = 1'b1;
          ram_raddr  = free_head;
          state_next = ST_STEP2;
        end else begin
          // Poison and free the erased slot and fetch its predecessor.
          link_a_next = p_prev;
          link_b_next = p_next;
          ram_we      = 1'b1;
          ram_waddr   = op_p;
          ram_wdata   = pack_word(poison, '0, '0, 1'b1);
          ram_re      = 1'b1;
          ram_raddr   = p_prev;
          state_next  = ST_STEP2;
        end
      end

      ST_STEP2: begin
        if (is_ins) begin
          // Pop the free list and fill the new slot; fetch the successor.
          free_head_next = q_next;
          if (q_next == '0) begin
            free_tail_next = '0;
          end
          ram_we    = 1'b1;
          ram_waddr = slot_n;
          ram_wdata = pack_word(op_val, link_a, op_p, 1'b0);
          ram_re    = 1'b1;
          ram_raddr = link_a;
        end else begin
          // Bridge the predecessor over the erased slot; fetch the successor.
          if (link_a == '0) begin
            head_next = link_b;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = link_a;
            ram_wdata = pack_word(q_data, link_b, q_prev, q_free);
          end
          ram_re    = 1'b1;
          ram_raddr = link_b;
        end
        state_next = ST_STEP3;
      end

      ST_STEP3: begin
        if (is_ins) begin
          // Point the successor back at the new slot and report.
          if (out_free) begin
            if (link_a == '0) begin
              tail_next = slot_n;
            end else begin
              ram_we    = 1'b1;
              ram_waddr = link_a;
              ram_wdata = pack_word(q_data, q_next, slot_n, q_free);
            end
            res_load   = 1'b1;
            res_slot_d = POS_BITS'(slot_n);
            state_next = ST_IDLE;
          end
        end else begin
          // Point the successor back at the predecessor; fetch the free list tail.
          if (link_b == '0) begin
            tail_next = link_a;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = link_b;
            ram_wdata = pack_word(q_data, q_next, link_a, q_free);
          end
          ram_re     = 1'b1;
          ram_raddr  = free_tail;
          state_next = ST_STEP4;
        end
      end

      // Append the erased slot to the free list and report.
      ST_STEP4: begin
        if (out_free) begin
          if (free_head == '0) begin
            free_head_next = op_p;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = free_tail;
            ram_wdata = pack_word(q_data, op_p, q_prev, q_free);
          end
          free_tail_next = op_p;
          res_load       = 1'b1;
          res_slot_d     = POS_BITS'(op_p);
          state_next     = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase

    res_head_d = POS_BITS'(head_next);
    res_tail_d = POS_BITS'(tail_next);
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_idx   <= '0;
      head      <= '0;
      tail      <= '0;
      free_head <= IW'(1);
      free_tail <= LAST_SLOT;
      res_valid <= 1'b0;
      poison    <= '0;
    end else begin
      state     <= state_next;
      clr_idx   <= clr_idx_next;
      head      <= head_next;
      tail      <= tail_next;
      free_head <= free_head_next;
      free_tail <= free_tail_next;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (res.ready) begin
        res_valid <= 1'b0;
      end
      if (cfg_we) begin
        poison <= DATA_BITS'($unsigned(cfg_data));
      end
    end
  end

  // Command and result payload.
  always_ff @(posedge clk) begin
    slot_n <= slot_n_next;
    link_a <= link_a_next;
    link_b <= link_b_next;
    if (accept) begin
      op_mode  <= cmd.mode;
      op_p     <= p_sel;
      op_val   <= DATA_BITS'($unsigned(cmd.value));
      op_range <= range_sel;
    end
    if (res_load) begin
      res_status <= res_status_d;
      res_slot   <= res_slot_d;
      res_head   <= res_head_d;
      res_tail   <= res_tail_d;
      res_rvalue <= res_rvalue_d;
      res_rnext  <= res_rnext_d;
      res_rprev  <= res_rprev_d;
      res_rfree  <= res_rfree_d;
    end
  end

  assign res.valid      = res_valid;
  assign res.status     = res_status;
  assign res.slot       = res_slot;
  assign res.head_index = res_head;
  assign res.tail_index = res_tail;
  assign res.read_value = res_rvalue;
  assign res.read_next  = res_rnext;
  assign res.read_prev  = res_rprev;
  assign res.read_free  = res_rfree;

  // Between commands the list is empty exactly when both sentinel links are clear.
  `ASSERT_IMPLIES(a_list_ends, clk, rst, state == ST_IDLE, (head == '0) == (tail == '0), "list ends")
  // The free list is empty exactly when both of its pointers are clear.
  `ASSERT_ALWAYS(a_free_ends, clk, rst, (free_head == '0) == (free_tail == '0), "free ends")
  // Outside initialization the sentinel lives in registers and is never written to memory.
  `ASSERT_IMPLIES(a_no_sentinel_write, clk, rst, ram_we && (state != ST_CLEAR), ram_waddr != '0, "sentinel slot written")

endmodule

@@ rtl/idll_ram.sv @@
`timescale 1ns / 1ps

// Simple dual-port RAM: one write and one registered read per cycle.
// A read and a write to the same address in one cycle return the old data.
module idll_ram #(
  parameter  int WIDTH = 8,
  parameter  int DEPTH = 64,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read data holds its value while no read is issued.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import idll_pkg::*;

  // Mode 7 has no meaning and is rejected as out of range.
  localparam logic [MODE_BITS-1:0] MODE_SPARE = 3'd7;
  localparam int NSLOT = SLOTS_DEF;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [MODE_BITS-1:0]       mode;
    logic [POS_BITS-1:0]        position;
    logic signed [VAL_BITS-1:0] value;
  } list_cmd_t;

  typedef struct packed {
    logic [STATUS_BITS-1:0]     status;
    logic [POS_BITS-1:0]        slot;
    logic [POS_BITS-1:0]        head_index;
    logic [POS_BITS-1:0]        tail_index;
    logic signed [VAL_BITS-1:0] read_value;
    logic [POS_BITS-1:0]        read_next;
    logic [POS_BITS-1:0]        read_prev;
    logic                       read_free;
  } list_result_t;

  logic                       clk;
  logic                       rst;
  logic                       cfg_we;
  logic signed [VAL_BITS-1:0] cfg_data;

  idll_cmd_if cmd_bus ();
  idll_res_if res_bus ();

  indexed_doubly_linked_list uut (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd_bus),
    .res      (res_bus),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  // Shadow copy of the slot table, the free list and the poison register.
  logic signed [VAL_BITS-1:0] slot_data [NSLOT];
  logic [POS_BITS-1:0]        slot_next [NSLOT];
  logic [POS_BITS-1:0]        slot_prev [NSLOT];
  logic                       slot_free [NSLOT];
  logic [POS_BITS-1:0]        free_first;
  logic [POS_BITS-1:0]        free_last;
  logic signed [VAL_BITS-1:0] poison_word;

  list_cmd_t    pending_cmds [$];
  list_result_t expected_results [$];
  int           error_count;
  int           send_idle_pct;
  int           recv_idle_pct;
  int           hold_requests;
  int           hold_served;
  int           hold_left;

  // Clock with a 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Takes the first free slot and links it after slot p.
  function automatic logic [STATUS_BITS-1:0] link_slot(input logic [POS_BITS-1:0] p,
                                                        input logic [VAL_BITS-1:0] v,
                                                        output logic [POS_BITS-1:0] s);
    logic [POS_BITS-1:0] n;
    logic [POS_BITS-1:0] after;
    s = '0;
    if (free_first == '0) return ST_FULL;
    if (slot_free[p]) return ST_BADSLOT;
    n = free_first;
    free_first = slot_next[n];
    if (free_first == '0) free_last = '0;
    after = slot_next[p];
    slot_data[n] = v;
    slot_prev[n] = p;
    slot_next[n] = after;
    slot_free[n] = 1'b0;
    slot_prev[after] = n;
    slot_next[p] = n;
    s = n;
    return ST_OK;
  endfunction

  // Unlinks slot p, poisons it and appends it to the free list.
  function automatic logic [STATUS_BITS-1:0] unlink_slot(input logic [POS_BITS-1:0] p,
                                                          output logic [POS_BITS-1:0] s);
    logic [POS_BITS-1:0] a;
    logic [POS_BITS-1:0] b;
    s = '0;
    if (slot_next[0] == '0) return ST_EMPTY;
    if (p == '0 || slot_free[p]) return ST_BADSLOT;
    a = slot_prev[p];
    b = slot_next[p];
    slot_next[a] = b;
    slot_prev[b] = a;
    slot_free[p] = 1'b1;
    slot_data[p] = poison_word;
    slot_next[p] = '0;
    slot_prev[p] = '0;
    if (free_first == '0) free_first = p;
    else slot_next[free_last] = p;
    free_last = p;
    s = p;
    return ST_OK;
  endfunction

  // Applies one command to the shadow table and returns the result word it must produce.
  // The table has exactly as many slots as a position can name, so only the spare
  // mode can be out of range.
  function automatic list_result_t predict_list_op(input list_cmd_t c);
    list_result_t r;
    logic [POS_BITS-1:0] s;
    r = '0;
    s = '0;
    case (c.mode)
      MODE_INS_AFTER:  r.status = link_slot(c.position, c.value, s);
      MODE_ERASE:      r.status = unlink_slot(c.position, s);
      MODE_INS_HEAD:   r.status = link_slot('0, c.value, s);
      MODE_INS_TAIL:   r.status = link_slot(slot_prev[0], c.value, s);
      MODE_ERASE_HEAD: r.status = unlink_slot(slot_next[0], s);
      MODE_ERASE_TAIL: r.status = unlink_slot(slot_prev[0], s);
      MODE_READ: begin
        r.status     = ST_OK;
        r.read_value = slot_data[c.position];
        r.read_next  = slot_next[c.position];
        r.read_prev  = slot_prev[c.position];
        r.read_free  = slot_free[c.position];
      end
      default:         r.status = ST_RANGE;
    endcase
    r.slot       = (r.status == ST_OK) ? s : '0;
    r.head_index = slot_next[0];
    r.tail_index = slot_prev[0];
    return r;
  endfunction

  // Command driver: offers the next pending word unless it chooses to idle.
  always @(posedge clk) begin
    list_cmd_t c;
    if (rst) begin
      cmd_bus.valid <= 1'b0;
    end else if (!cmd_bus.valid || cmd_bus.ready) begin
      if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        c = pending_cmds.pop_front();
        cmd_bus.valid    <= 1'b1;
        cmd_bus.mode     <= c.mode;
        cmd_bus.position <= c.position;
        cmd_bus.value    <= c.value;
      end else begin
        cmd_bus.valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, counted here so the block backs up into its input.
  always @(posedge clk) begin
    if (rst) begin
      hold_left   <= 0;
      hold_served <= 0;
    end else if (hold_served != hold_requests) begin
      hold_left   <= HOLD_CYCLES;
      hold_served <= hold_requests;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Result receiver ready with random stalls.
  always @(posedge clk) begin
    res_bus.ready <= !rst && hold_left == 0 && $urandom_range(99) >= recv_idle_pct;
  end

  // Monitor: predicts each accepted command and checks each accepted result word.
  // In reset it loads the shadow table with the reset contents.
  always @(posedge clk) begin
    list_cmd_t    c;
    list_result_t got;
    list_result_t want;
    if (rst) begin
      error_count = 0;
      for (int i = 0; i < NSLOT; i++) begin
        slot_data[i] = '0;
        slot_next[i] = (i + 1 < NSLOT) ? POS_BITS'(i + 1) : '0;
        slot_prev[i] = '0;
        slot_free[i] = 1'b1;
      end
      slot_next[0] = '0;
      slot_free[0] = 1'b0;
      free_first   = POS_BITS'(1);
      free_last    = POS_BITS'(NSLOT - 1);
    end else begin
      if (res_bus.valid && res_bus.ready) begin
        got.status     = res_bus.status;
        got.slot       = res_bus.slot;
        got.head_index = res_bus.head_index;
        got.tail_index = res_bus.tail_index;
        got.read_value = res_bus.read_value;
        got.read_next  = res_bus.read_next;
        got.read_prev  = res_bus.read_prev;
        got.read_free  = res_bus.read_free;
        if (expected_results.size() == 0) begin
          error_count = error_count + 1;
          if (error_count <= 10)
            $display("ERROR %0t: unexpected result word status=%0d slot=%0d", $realtime,
                     got.status, got.slot);
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status || got.slot !== want.slot ||
              got.head_index !== want.head_index || got.tail_index !== want.tail_index ||
              got.read_value !== want.read_value || got.read_next !== want.read_next ||
              got.read_prev !== want.read_prev || got.read_free !== want.read_free) begin
            error_count = error_count + 1;
            if (error_count <= 10) begin
              $display("ERROR %0t: result word mismatch", $realtime);
              $display("  expected st=%0d slot=%0d head=%0d tail=%0d rv=%h rn=%0d rp=%0d rf=%0d",
                       want.status, want.slot, want.head_index, want.tail_index,
                       want.read_value, want.read_next, want.read_prev, want.read_free);
              $display("  actual   st=%0d slot=%0d head=%0d tail=%0d rv=%h rn=%0d rp=%0d rf=%0d",
                       got.status, got.slot, got.head_index, got.tail_index,
                       got.read_value, got.read_next, got.read_prev, got.read_free);
            end
          end
        end
      end
      if (cmd_bus.valid && cmd_bus.ready) begin
        c.mode     = cmd_bus.mode;
        c.position = cmd_bus.position;
        c.value    = cmd_bus.value;
        expected_results.push_back(predict_list_op(c));
      end
    end
  end

  // Waits until no command is queued or in flight and every result word has arrived.
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_cmds.size() != 0 || cmd_bus.valid || expected_results.size() != 0);
  endtask

  // Writes the poison register; only called while no command is in flight.
  task automatic write_poison(input logic [VAL_BITS-1:0] v);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we      <= 1'b0;
    poison_word  = v;
    @(negedge clk);
  endtask

  task automatic push_cmd(input logic [MODE_BITS-1:0] m, input logic [POS_BITS-1:0] p,
                          input logic [VAL_BITS-1:0] v);
    list_cmd_t c;
    c.mode     = m;
    c.position = p;
    c.value    = v;
    pending_cmds.push_back(c);
  endtask

  // One random phase. Fill phases lean on inserts to reach a full table, drain phases
  // lean on erases to reach an empty list. Positions mostly name a slot on the list.
  task automatic run_phase(input int count, input bit fill, input int send_pct,
                           input int recv_pct, input logic [VAL_BITS-1:0] poison,
                           input bit hold);
    int r;
    int live_count;
    int pick;
    logic [MODE_BITS-1:0] m;
    logic [POS_BITS-1:0]  p;
    logic [VAL_BITS-1:0]  v;
    wait_idle();
    repeat (8) @(negedge clk);
    write_poison(poison);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    if (hold) hold_requests = hold_requests + 1;
    for (int k = 0; k < count; k++) begin
      while (pending_cmds.size() >= 2) @(negedge clk);
      r = $urandom_range(99);
      if (fill) begin
        if (r < 25) m = MODE_INS_AFTER;
        else if (r < 45) m = MODE_INS_HEAD;
        else if (r < 65) m = MODE_INS_TAIL;
        else if (r < 73) m = MODE_ERASE;
        else if (r < 79) m = MODE_ERASE_HEAD;
        else if (r < 85) m = MODE_ERASE_TAIL;
        else if (r < 96) m = MODE_READ;
        else m = MODE_SPARE;
      end else begin
        if (r < 8) m = MODE_INS_AFTER;
        else if (r < 14) m = MODE_INS_HEAD;
        else if (r < 20) m = MODE_INS_TAIL;
        else if (r < 45) m = MODE_ERASE;
        else if (r < 62) m = MODE_ERASE_HEAD;
        else if (r < 80) m = MODE_ERASE_TAIL;
        else if (r < 96) m = MODE_READ;
        else m = MODE_SPARE;
      end
      live_count = 0;
      for (int i = 1; i < NSLOT; i++)
        if (!slot_free[i]) live_count++;
      p = POS_BITS'($urandom_range(NSLOT - 1));
      if (live_count != 0 && $urandom_range(99) < 75) begin
        pick = $urandom_range(live_count - 1);
        for (int i = 1; i < NSLOT; i++) begin
          if (!slot_free[i]) begin
            if (pick == 0) p = POS_BITS'(i);
            pick--;
          end
        end
      end
      r = $urandom_range(9);
      if (r == 0) v = 32'h7FFF_FFFF;
      else if (r == 1) v = 32'h8000_0000;
      else v = $urandom;
      push_cmd(m, p, v);
    end
  endtask

  // Limit on the whole run.
  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

  // Stimulus: reset, a directed part, then random phases over several poison values.
  initial begin
    clk              = 1'b0;
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_data         = '0;
    hold_requests    = 0;
    send_idle_pct    = 28;
    recv_idle_pct    = 80;
    poison_word      = '0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    write_poison(32'h8000_0000);

    // Empty-list erases, reads of the sentinel and of a free slot, insert after a free slot.
    push_cmd(MODE_ERASE_HEAD, 6'd0, 32'd0);
    push_cmd(MODE_ERASE_TAIL, 6'd63, 32'd0);
    push_cmd(MODE_ERASE, 6'd5, 32'd0);
    push_cmd(MODE_READ, 6'd0, 32'd0);
    push_cmd(MODE_READ, 6'd63, 32'hFFFF_FFFF);
    push_cmd(MODE_INS_AFTER, 6'd3, 32'h1234_5678);
    // Build a short list through every insert mode, including insert after the sentinel.
    push_cmd(MODE_INS_HEAD, 6'd63, 32'h7FFF_FFFF);
    push_cmd(MODE_INS_TAIL, 6'd0, 32'h8000_0000);
    push_cmd(MODE_INS_AFTER, 6'd0, 32'hFFFF_FFFF);
    push_cmd(MODE_INS_AFTER, 6'd1, 32'd0);
    push_cmd(MODE_READ, 6'd1, 32'd0);
    push_cmd(MODE_READ, 6'd4, 32'd0);
    // Spare mode, erase of the sentinel and of a free slot.
    push_cmd(MODE_SPARE, 6'd63, 32'hFFFF_FFFF);
    push_cmd(MODE_ERASE, 6'd0, 32'd0);
    push_cmd(MODE_ERASE, 6'd63, 32'd0);
    // Erase from the middle, then read the freed slot back.
    push_cmd(MODE_ERASE, 6'd4, 32'd0);
    push_cmd(MODE_READ, 6'd4, 32'd0);
    push_cmd(MODE_INS_AFTER, 6'd2, 32'd1);
    push_cmd(MODE_ERASE_TAIL, 6'd0, 32'd0);
    push_cmd(MODE_ERASE_HEAD, 6'd0, 32'd0);
    push_cmd(MODE_READ, 6'd0, 32'd0);
    push_cmd(MODE_INS_TAIL, 6'd42, 32'h5555_5555);
    push_cmd(MODE_INS_HEAD, 6'd21, 32'hAAAA_AAAA);

    run_phase(225, 1'b1, 28, 80, 32'h7FFF_FFFF, 1'b0);
    run_phase(225, 1'b0, 28, 80, 32'd0, 1'b0);
    run_phase(225, 1'b1, 80, 28, 32'hFFFF_FFFF, 1'b0);
    run_phase(225, 1'b0, 80, 28, $urandom, 1'b0);
    run_phase(225, 1'b1, 0, 0, 32'd1, 1'b1);
    run_phase(225, 1'b0, 0, 0, $urandom, 1'b0);

    wait_idle();
    repeat (20) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
